@@ design/cpid_pkg.sv @@
`default_nettype none

package cpid_pkg;

	// Fixed-point layout: Q.12 fractions throughout the loops
	localparam int FRAC_BITS = 12;
	localparam int ACC_W     = 53;  // 17 x 36 signed product, also holds any loop total
	localparam int LIM_W     = 28;  // clamped integrals for any limit up to 32767 counts
	localparam int INTEG_W   = 48;  // inner integral saturates to this range

	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [35:0]        opnd_t;
	typedef logic signed [32:0]        err_t;
	typedef logic signed [33:0]        diff_t;
	typedef logic signed [34:0]        sum3_t;
	typedef logic signed [INTEG_W-1:0] integ_t;
	typedef logic signed [LIM_W-1:0]   lim_t;
	typedef logic [15:0]               gain_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SPEED_KP   = 3'd0,
		REG_SPEED_KI   = 3'd1,
		REG_SPEED_KD   = 3'd2,
		REG_ANGLE_KP   = 3'd3,
		REG_ANGLE_KI   = 3'd4,
		REG_ANGLE_KD   = 3'd5,
		REG_CASCADE    = 3'd6,
		REG_ERR_THRESH = 3'd7
	} reg_idx_t;

	// Request to the shared multiplier
	typedef struct packed {
		logic  en;
		gain_t gain;
		opnd_t opnd;
	} mul_req_t;

	localparam acc_t INTEG_MAX = acc_t'(48'sh7FFF_FFFF_FFFF);
	localparam acc_t INTEG_MIN = acc_t'(48'sh8000_0000_0000);
	localparam acc_t FRAC_MASK = acc_t'(12'hFFF);
	localparam acc_t QTR_MASK  = acc_t'(2'h3);

	// Symmetric clamp to +-lim, lim non-negative
	function automatic acc_t clamp_acc(input acc_t v, input acc_t lim);
		acc_t r;
		r = v;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		return r;
	endfunction

	// Drop the fraction, rounding toward zero
	function automatic acc_t trunc_frac(input acc_t v);
		acc_t t;
		t = v + (v[ACC_W-1] ? FRAC_MASK : '0);
		return t >>> FRAC_BITS;
	endfunction

	// Divide by four, rounding toward zero
	function automatic acc_t quarter(input acc_t v);
		acc_t t;
		t = v + (v[ACC_W-1] ? QTR_MASK : '0);
		return t >>> 2;
	endfunction

	// Saturate to the 48-bit signed range
	function automatic integ_t sat_integ(input acc_t v);
		acc_t r;
		r = v;
		if (v > INTEG_MAX)
			r = INTEG_MAX;
		else if (v < INTEG_MIN)
			r = INTEG_MIN;
		return r[INTEG_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/cascade_pid_position_speed.sv @@
`default_nettype none

// Cascaded position/speed PID controller, one control tick per input transaction.
// Input channel (in_valid/in_stall) carries setpoint, position_feedback and
// speed_feedback; output channel (out_valid/out_stall) returns drive and
// outer_output. Gains, mode and error threshold are written on the cfg port;
// the user must write them only while the block is idle; the block itself does not enforce this.
// A tick runs through the outer states O0 to O6 (cascade mode only), then the inner
// states I0 to I4 and DONE before out_valid rises. A new transaction is taken
// only once the sequencer is back in idle, so ticks do not overlap. The pace is
// set by the single shared multiplier, used three times per loop, and the
// add/clamp step that follows each product.
// in_stall is high while a tick is being computed. A finished result sits in
// the output register; the next tick can be accepted meanwhile, and if its
// result is ready before the old one is taken, the sequencer holds it until
// out_stall drops.
// Reset restores the default gains and mode and clears all loop state.
module cascade_pid_position_speed #(
	parameter int SPEED_I_LIMIT   = 5000,
	parameter int SPEED_OUT_LIMIT = 16384,
	parameter int ANGLE_I_LIMIT   = 1000,
	parameter int ANGLE_OUT_LIMIT = 10000,
	parameter int ANGLE_P_LIMIT   = 8000,
	parameter int ANGLE_D_LIMIT   = 1000
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] setpoint,
	input  wire logic signed [31:0] position_feedback,
	input  wire logic signed [15:0] speed_feedback,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      drive,
	output logic signed [31:0]      outer_output,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam cpid_pkg::acc_t SPD_I_LIM = cpid_pkg::acc_t'(SPEED_I_LIMIT) <<< cpid_pkg::FRAC_BITS;
	localparam cpid_pkg::acc_t SPD_O_LIM = cpid_pkg::acc_t'(SPEED_OUT_LIMIT) <<< cpid_pkg::FRAC_BITS;
	localparam cpid_pkg::acc_t ANG_I_LIM = cpid_pkg::acc_t'(ANGLE_I_LIMIT) <<< cpid_pkg::FRAC_BITS;
	localparam cpid_pkg::acc_t ANG_O_LIM = cpid_pkg::acc_t'(ANGLE_OUT_LIMIT) <<< cpid_pkg::FRAC_BITS;
	localparam cpid_pkg::acc_t ANG_P_LIM = cpid_pkg::acc_t'(ANGLE_P_LIMIT) <<< cpid_pkg::FRAC_BITS;
	localparam cpid_pkg::acc_t ANG_D_LIM = cpid_pkg::acc_t'(ANGLE_D_LIMIT) <<< cpid_pkg::FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_O0, ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6,
		ST_I0, ST_I1, ST_I2, ST_I3, ST_I4,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	cpid_pkg::gain_t    speed_kp_q, speed_ki_q, speed_kd_q;
	cpid_pkg::gain_t    angle_kp_q, angle_ki_q, angle_kd_q;
	logic               cascade_q;
	logic signed [31:0] err_thresh_q;

	// Loop state carried between ticks
	cpid_pkg::err_t   ile_q;
	cpid_pkg::integ_t ii_q;
	cpid_pkg::err_t   oerr_q, olerr_q;
	cpid_pkg::lim_t   oint_q;

	// Working registers for one tick
	logic signed [31:0] sp_q, pos_q;
	logic signed [15:0] spd_q;
	cpid_pkg::err_t     eo_q, ei_q;
	cpid_pkg::diff_t    dlt_q, dli_q;
	cpid_pkg::sum3_t    osum_q;
	cpid_pkg::lim_t     icl_q;
	logic               hit_q;
	cpid_pkg::acc_t     acc_q;
	logic signed [31:0] outer_q;
	logic signed [15:0] drive_q;
	logic signed [31:0] outer_output_q;
	logic               out_valid_q;

	cpid_pkg::mul_req_t mul_req;
	cpid_pkg::acc_t     prod_q;

	cpid_pkg::acc_t ilim, olim;
	cpid_pkg::acc_t oint_nxt, icl_nxt, outer_nxt, drive_nxt;
	cpid_pkg::err_t tgt;
	logic           in_acc, out_free;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign drive        = drive_q;
	assign outer_output = outer_output_q;

	cpid_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	// Pick the multiplier operands for the current step
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_O1: begin
				mul_req.en   = 1'b1;
				mul_req.gain = angle_kp_q;
				mul_req.opnd = cpid_pkg::opnd_t'(eo_q);
			end
			ST_O2: begin
				mul_req.en   = 1'b1;
				mul_req.gain = angle_kd_q;
				mul_req.opnd = cpid_pkg::opnd_t'(dlt_q);
			end
			ST_O3: begin
				mul_req.en   = 1'b1;
				mul_req.gain = angle_ki_q;
				mul_req.opnd = cpid_pkg::opnd_t'(osum_q);
			end
			ST_I1: begin
				mul_req.en   = 1'b1;
				mul_req.gain = speed_kp_q;
				mul_req.opnd = cpid_pkg::opnd_t'(ei_q);
			end
			ST_I2: begin
				mul_req.en   = 1'b1;
				mul_req.gain = speed_ki_q;
				mul_req.opnd = cpid_pkg::opnd_t'(ei_q);
			end
			ST_I3: begin
				mul_req.en   = 1'b1;
				mul_req.gain = speed_kd_q;
				mul_req.opnd = cpid_pkg::opnd_t'(dli_q);
			end
			default: mul_req = '0;
		endcase
	end

	// Mode-dependent limits and per-step add/clamp results
	always_comb begin
		ilim      = cascade_q ? ANG_I_LIM : SPD_I_LIM;
		olim      = cascade_q ? ANG_O_LIM : SPD_O_LIM;
		tgt       = cascade_q ? cpid_pkg::err_t'(outer_q) : cpid_pkg::err_t'(sp_q);
		oint_nxt  = cpid_pkg::clamp_acc(cpid_pkg::acc_t'(oint_q) + cpid_pkg::quarter(prod_q),
			ANG_I_LIM);
		icl_nxt   = cpid_pkg::clamp_acc(cpid_pkg::acc_t'(ii_q), ilim);
		outer_nxt = cpid_pkg::trunc_frac(acc_q);
		drive_nxt = cpid_pkg::trunc_frac(cpid_pkg::clamp_acc(acc_q, olim));
	end

	// Sequencer, configuration, loop state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			drive_q        <= '0;
			outer_output_q <= '0;
			speed_kp_q     <= 16'd1024;
			speed_ki_q     <= 16'd0;
			speed_kd_q     <= 16'd12288;
			angle_kp_q     <= 16'd4096;
			angle_ki_q     <= 16'd41;
			angle_kd_q     <= 16'd0;
			cascade_q      <= 1'b0;
			err_thresh_q   <= 32'sh7FFF_FFFF;
			ile_q          <= '0;
			ii_q           <= '0;
			oerr_q         <= '0;
			olerr_q        <= '0;
			oint_q         <= '0;
		end else begin
			// Register writes
			if (cfg_we) begin
				unique case (cpid_pkg::reg_idx_t'(cfg_index))
					cpid_pkg::REG_SPEED_KP:   speed_kp_q   <= cfg_data[15:0];
					cpid_pkg::REG_SPEED_KI:   speed_ki_q   <= cfg_data[15:0];
					cpid_pkg::REG_SPEED_KD:   speed_kd_q   <= cfg_data[15:0];
					cpid_pkg::REG_ANGLE_KP:   angle_kp_q   <= cfg_data[15:0];
					cpid_pkg::REG_ANGLE_KI:   angle_ki_q   <= cfg_data[15:0];
					cpid_pkg::REG_ANGLE_KD:   angle_kd_q   <= cfg_data[15:0];
					cpid_pkg::REG_CASCADE:    cascade_q    <= cfg_data[0];
					cpid_pkg::REG_ERR_THRESH: err_thresh_q <= cfg_data;
				endcase
			end

			// Drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= cascade_q ? ST_O0 : ST_I0;
				end
				ST_O0: state_q <= ST_O1;
				ST_O1: state_q <= ST_O2;
				ST_O2: state_q <= ST_O3;
				ST_O3: state_q <= ST_O4;
				ST_O4: begin
					oint_q  <= oint_nxt[cpid_pkg::LIM_W-1:0];
					state_q <= ST_O5;
				end
				ST_O5: begin
					// Shift the outer error history
					olerr_q <= oerr_q;
					oerr_q  <= eo_q;
					state_q <= ST_O6;
				end
				ST_O6: state_q <= ST_I0;
				ST_I0: state_q <= ST_I1;
				ST_I1: state_q <= ST_I2;
				ST_I2: state_q <= ST_I3;
				ST_I3: begin
					ii_q    <= hit_q ? '0 : cpid_pkg::sat_integ(cpid_pkg::acc_t'(icl_q) + prod_q);
					state_q <= ST_I4;
				end
				ST_I4: begin
					ile_q   <= ei_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						out_valid_q    <= 1'b1;
						drive_q        <= drive_nxt[15:0];
						outer_output_q <= cascade_q ? outer_q : '0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the current tick
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					sp_q  <= setpoint;
					pos_q <= position_feedback;
					spd_q <= speed_feedback;
				end
			end
			ST_O0: begin
				eo_q  <= cpid_pkg::err_t'(sp_q) - cpid_pkg::err_t'(pos_q);
				dlt_q <= cpid_pkg::diff_t'(oerr_q) - cpid_pkg::diff_t'(olerr_q);
			end
			ST_O1: begin
				osum_q <= cpid_pkg::sum3_t'(eo_q) + cpid_pkg::sum3_t'(oerr_q)
					+ cpid_pkg::sum3_t'(olerr_q);
			end
			ST_O2: acc_q <= cpid_pkg::clamp_acc(prod_q, ANG_P_LIM);
			ST_O3: acc_q <= acc_q + cpid_pkg::clamp_acc(prod_q, ANG_D_LIM);
			ST_O5: acc_q <= acc_q + cpid_pkg::acc_t'(oint_q);
			ST_O6: outer_q <= outer_nxt[31:0];
			ST_I0: ei_q <= tgt - cpid_pkg::err_t'(spd_q);
			ST_I1: begin
				dli_q <= cpid_pkg::diff_t'(ei_q) - cpid_pkg::diff_t'(ile_q);
				hit_q <= (ei_q >= cpid_pkg::err_t'(err_thresh_q));
				icl_q <= icl_nxt[cpid_pkg::LIM_W-1:0];
			end
			ST_I2: acc_q <= hit_q ? (prod_q >>> 1) : prod_q;
			ST_I4: acc_q <= acc_q + prod_q + cpid_pkg::acc_t'(ii_q);
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ design/cpid_mul.sv @@
`default_nettype none

// Shared gain multiplier: unsigned Q4.12 gain times signed operand, product registered
module cpid_mul (
	input  wire logic               clk,
	input  wire cpid_pkg::mul_req_t req,
	output cpid_pkg::acc_t          prod_q
);

	logic signed [16:0] gain_s;
	cpid_pkg::acc_t     prod;

	// Zero-extend the gain so the product stays signed
	assign gain_s = $signed({1'b0, req.gain});
	assign prod   = cpid_pkg::acc_t'(gain_s) * cpid_pkg::acc_t'(req.opnd);

	// Capture only on issued requests, hold otherwise
	always_ff @(posedge clk) begin
		if (req.en)
			prod_q <= prod;
	end

endmodule

`default_nettype wire

@@ design/cpid_chk.sv @@
`default_nettype none

// Port-level checks for the cascaded PID controller
module cpid_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] drive,
	input wire logic signed [31:0] outer_output
);

	// A tick in progress blocks further input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while previous tick still in progress");

	// No result can appear in the cycle right after a transaction is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early after input");

	// Stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// Stalled payload holds
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(drive) && $stable(outer_output))
		else $error("result payload changed while stalled");

endmodule

bind cascade_pid_position_speed cpid_chk u_cpid_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.drive        (drive),
	.outer_output (outer_output)
);

`default_nettype wire

@@ sim/cascade_pid_position_speed_tb.sv @@
`timescale 1ns / 100ps

module cascade_pid_position_speed_tb;

	localparam longint SPEED_I_LIMIT   = 5000;
	localparam longint SPEED_OUT_LIMIT = 16384;
	localparam longint ANGLE_I_LIMIT   = 1000;
	localparam longint ANGLE_OUT_LIMIT = 10000;
	localparam longint ANGLE_P_LIMIT   = 8000;
	localparam longint ANGLE_D_LIMIT   = 1000;
	localparam longint Q12             = 12;
	localparam longint INT48_HI        = 64'sh7FFF_FFFF_FFFF;
	localparam longint INT48_LO        = -INT48_HI - 1;
	localparam int     CYCLE_LIMIT     = 400000;
	localparam int     TICKS_PER_SET   = 125;
	localparam int     RANDOM_SETS     = 10;

	typedef struct {
		logic signed [31:0] sp;
		logic signed [31:0] pos;
		logic signed [15:0] spd;
		bit                 drain;
	} tick_t;

	typedef struct {
		logic signed [15:0] drive;
		logic signed [31:0] outer;
	} drive_t;

	logic               clk               = 1'b0;
	logic               arst_n            = 1'b0;
	logic               in_valid          = 1'b0;
	logic               in_stall;
	logic signed [31:0] setpoint          = '0;
	logic signed [31:0] position_feedback = '0;
	logic signed [15:0] speed_feedback    = '0;
	logic               out_valid;
	logic               out_stall         = 1'b0;
	logic signed [15:0] drive;
	logic signed [31:0] outer_output;
	logic               cfg_we            = 1'b0;
	logic [2:0]         cfg_index         = '0;
	logic [31:0]        cfg_data          = '0;

	// Register shadow and loop state of the controller
	logic [31:0] shadow [8] = '{32'd1024, 32'd0, 32'd12288, 32'd4096, 32'd41, 32'd0,
		32'd0, 32'h7FFF_FFFF};
	longint spd_prev_err = 0;
	longint spd_integ    = 0;
	longint pos_err_1    = 0;
	longint pos_err_2    = 0;
	longint pos_integ    = 0;

	tick_t  pending [$];
	drive_t drive_q [$];

	bit in_taken  = 1'b0;
	bit calm      = 1'b0;
	bit hold_ask  = 1'b0;
	int hold_left = 0;
	int cycles    = 0;
	int errors    = 0;
	int n_checked = 0;
	int n_cascade = 0;
	int n_settings = 0;

	cascade_pid_position_speed u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.setpoint          (setpoint),
		.position_feedback (position_feedback),
		.speed_feedback    (speed_feedback),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.drive             (drive),
		.outer_output      (outer_output),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint drop_frac(input longint v);
		return (v >= 0) ? (v >>> Q12) : -((-v) >>> Q12);
	endfunction

	function automatic longint quarter_tz(input longint v);
		return (v >= 0) ? (v >>> 2) : -((-v) >>> 2);
	endfunction

	function automatic longint gain(input cpid_pkg::reg_idx_t r);
		return longint'(shadow[r][15:0]);
	endfunction

	// Inner speed PID: clamp the integral before adding, halve P at or past the threshold
	function automatic longint speed_loop(input longint target, input longint fb,
		input longint ilim, input longint olim);
		longint e, p, i, d, thr;
		e   = target - fb;
		p   = gain(cpid_pkg::REG_SPEED_KP) * e;
		thr = longint'(signed'(shadow[cpid_pkg::REG_ERR_THRESH]));
		if (e < thr) begin
			i = clamp_sym(spd_integ, ilim << Q12) + gain(cpid_pkg::REG_SPEED_KI) * e;
			if (i > INT48_HI)
				i = INT48_HI;
			else if (i < INT48_LO)
				i = INT48_LO;
			spd_integ = i;
		end else begin
			p = p >>> 1;
			spd_integ = 0;
		end
		d = gain(cpid_pkg::REG_SPEED_KD) * (e - spd_prev_err);
		spd_prev_err = e;
		return drop_frac(clamp_sym(p + spd_integ + d, olim << Q12));
	endfunction

	// Outer position PID: separate P, I and D clamps, delayed D, quartered I step
	function automatic longint position_loop(input longint target, input longint fb);
		longint e, p, i, d;
		e = target - fb;
		p = clamp_sym(gain(cpid_pkg::REG_ANGLE_KP) * e, ANGLE_P_LIMIT << Q12);
		i = pos_integ + quarter_tz(gain(cpid_pkg::REG_ANGLE_KI) *
			(e + pos_err_1 + pos_err_2));
		d = clamp_sym(gain(cpid_pkg::REG_ANGLE_KD) * (pos_err_1 - pos_err_2),
			ANGLE_D_LIMIT << Q12);
		i = clamp_sym(i, ANGLE_I_LIMIT << Q12);
		pos_integ = i;
		pos_err_2 = pos_err_1;
		pos_err_1 = e;
		return drop_frac(p + i + d);
	endfunction

	function automatic drive_t control_tick(input longint sp, input longint pos,
		input longint spd);
		drive_t r;
		longint outer_tot, drv;
		outer_tot = 0;
		if (shadow[cpid_pkg::REG_CASCADE][0]) begin
			outer_tot = position_loop(sp, pos);
			drv = speed_loop(outer_tot, spd, ANGLE_I_LIMIT, ANGLE_OUT_LIMIT);
			n_cascade++;
		end else begin
			drv = speed_loop(sp, spd, SPEED_I_LIMIT, SPEED_OUT_LIMIT);
		end
		r.drive = drv[15:0];
		r.outer = outer_tot[31:0];
		return r;
	endfunction

	// Check results against the oldest expectation, then predict new transactions
	always @(posedge clk) begin : monitor
		drive_t want;
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result drive %0d outer_output %0d", $time,
					drive, outer_output);
			end else begin
				want = drive_q.pop_front();
				n_checked++;
				if (drive !== want.drive) begin
					errors++;
					$display("%0t: drive expected %0d actual %0d", $time,
						want.drive, drive);
				end
				if (outer_output !== want.outer) begin
					errors++;
					$display("%0t: outer_output expected %0d actual %0d", $time,
						want.outer, outer_output);
				end
			end
		end
		if (in_taken)
			drive_q.push_back(control_tick(setpoint, position_feedback, speed_feedback));
	end

	// Offer pending transactions; hold the payload until it is taken
	always @(negedge clk) begin : driver
		tick_t t;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending.size() != 0 && !(pending[0].drain && drive_q.size() != 0) &&
				(calm || $urandom_range(99) >= 6)) begin
				t = pending.pop_front();
				in_valid          <= 1'b1;
				setpoint          <= t.sp;
				position_feedback <= t.pos;
				speed_feedback    <= t.spd;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random, or for a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_ask) begin
			hold_ask  = 1'b0;
			hold_left = 80;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 6);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				drive_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input cpid_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			cpid_pkg::REG_CASCADE:    shadow[idx] = val & 32'h1;
			cpid_pkg::REG_ERR_THRESH: shadow[idx] = val;
			default:                  shadow[idx] = val & 32'hFFFF;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(input logic [15:0] skp, input logic [15:0] ski,
		input logic [15:0] skd, input logic [15:0] akp, input logic [15:0] aki,
		input logic [15:0] akd, input bit casc, input logic [31:0] thr);
		write_reg(cpid_pkg::REG_SPEED_KP, {16'h0, skp});
		write_reg(cpid_pkg::REG_SPEED_KI, {16'h0, ski});
		write_reg(cpid_pkg::REG_SPEED_KD, {16'h0, skd});
		write_reg(cpid_pkg::REG_ANGLE_KP, {16'h0, akp});
		write_reg(cpid_pkg::REG_ANGLE_KI, {16'h0, aki});
		write_reg(cpid_pkg::REG_ANGLE_KD, {16'h0, akd});
		write_reg(cpid_pkg::REG_CASCADE, {31'h0, casc});
		write_reg(cpid_pkg::REG_ERR_THRESH, thr);
		n_settings++;
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(5))
			0:       return 32'h0;
			1:       return 32'hFFFF;
			2, 3:    return $urandom_range(8192);
			default: return $urandom & 32'hFFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_thr();
		case ($urandom_range(5))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2, 3:    return int'($urandom_range(600)) - 300;
			default: return $urandom;
		endcase
	endfunction

	// Gains carry junk in the upper half to exercise the width masking
	task automatic random_settings(input bit casc);
		write_reg(cpid_pkg::REG_SPEED_KP, ($urandom & 32'hFFFF_0000) | rand_gain());
		write_reg(cpid_pkg::REG_SPEED_KI, ($urandom & 32'hFFFF_0000) | rand_gain());
		write_reg(cpid_pkg::REG_SPEED_KD, ($urandom & 32'hFFFF_0000) | rand_gain());
		write_reg(cpid_pkg::REG_ANGLE_KP, ($urandom & 32'hFFFF_0000) | rand_gain());
		write_reg(cpid_pkg::REG_ANGLE_KI, ($urandom & 32'hFFFF_0000) | rand_gain());
		write_reg(cpid_pkg::REG_ANGLE_KD, ($urandom & 32'hFFFF_0000) | rand_gain());
		write_reg(cpid_pkg::REG_CASCADE, ($urandom & 32'hFFFF_FFFE) | {31'h0, casc});
		write_reg(cpid_pkg::REG_ERR_THRESH, rand_thr());
		n_settings++;
	endtask

	function automatic logic [31:0] edge32();
		case ($urandom_range(3))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Mostly tracking ticks near the loop's operating point, some extremes and noise
	function automatic tick_t rand_tick(input bit casc);
		tick_t t;
		int base;
		logic [31:0] tmp;
		t.drain = 1'b0;
		case ($urandom_range(9))
			0: begin
				t.sp  = $urandom;
				t.pos = $urandom;
				tmp   = $urandom;
				t.spd = tmp[15:0];
			end
			1: begin
				t.sp  = edge32();
				t.pos = edge32();
				tmp   = edge32();
				t.spd = tmp[31:16];
			end
			default: begin
				if (casc) begin
					base  = $urandom;
					t.pos = base;
					t.sp  = base + int'($urandom_range(6000)) - 3000;
					t.spd = 16'(int'($urandom_range(6000)) - 3000);
				end else begin
					base  = int'($urandom_range(40000)) - 20000;
					t.sp  = base;
					t.spd = 16'(base + int'($urandom_range(600)) - 300);
					t.pos = $urandom;
				end
			end
		endcase
		return t;
	endfunction

	function automatic void offer(input logic [31:0] sp, input logic [31:0] pos,
		input logic [15:0] spd);
		tick_t t;
		t.sp    = sp;
		t.pos   = pos;
		t.spd   = spd;
		t.drain = 1'b0;
		pending.push_back(t);
	endfunction

	task automatic wait_idle();
		while (pending.size() != 0 || in_valid || drive_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin : stimulus
		tick_t t;
		bit casc;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings: speed mode, threshold reached only at the top of the range
		offer(32'h0, 32'h0, 16'h0);
		offer(32'h7FFF_FFFF, 32'h0, 16'h8000);
		offer(32'h8000_0000, 32'h0, 16'h7FFF);
		offer(32'd100, 32'h0, 16'd100);
		offer(32'hFFFF_FFFF, 32'h0, 16'h0);
		wait_idle();

		// Lowest threshold: P always halved, odd negative products round down
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1000, 16'd41, 16'h0, 1'b0, 32'h8000_0000);
		offer(32'hFFFF_FFFD, 32'h0, 16'h0);
		offer(32'd5, 32'h0, 16'h0);
		offer(32'h0, 32'h0, 16'h7FFF);
		offer(32'h0, 32'h0, 16'h8000);
		wait_idle();

		// Highest gains below the threshold: drive the inner integral into saturation
		set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1000, 16'd41, 16'h0, 1'b0, 32'h7FFF_FFFF);
		repeat (3) offer(32'h8000_0000, 32'h0, 16'h7FFF);
		offer(32'h7FFF_FFFF, 32'h0, 16'h1);
		wait_idle();

		// Cascade with full outer gains: P, I and D clamps and the quartered I step
		set_all(16'h1000, 16'd41, 16'h3000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
			32'h7FFF_FFFF);
		offer(32'd1000000, 32'h0, 16'h0);
		offer(32'hFFF0_BDC0, 32'h0, 16'h0);
		offer(32'd3, 32'h0, 16'h0);
		offer(32'hFFFF_FFF9, 32'h0, 16'h0);
		offer(32'h7FFF_FFFF, 32'h8000_0000, 16'h0);
		offer(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
		wait_idle();

		// Random settings, alternating modes; some sets stress the handshake
		for (int s = 0; s < RANDOM_SETS; s++) begin
			casc = s[0];
			random_settings(casc);
			if (s == 5)
				calm = 1'b1;
			for (int k = 0; k < TICKS_PER_SET; k++) begin
				t = rand_tick(casc);
				t.drain = (s == 7) && (k % 25 == 24);
				pending.push_back(t);
			end
			if (s == 3)
				hold_ask = 1'b1;
			wait_idle();
			calm = 1'b0;
		end

		$display("Checked %0d ticks, %0d in cascade mode, over %0d register settings", n_checked,
			n_cascade, n_settings + 1);
		$display("with random stalls, a long output hold-off and drained pauses");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ cascade_pid_position_speed.f @@
design/cpid_pkg.sv
design/cpid_mul.sv
design/cascade_pid_position_speed.sv
design/cpid_chk.sv
sim/cascade_pid_position_speed_tb.sv
